@@ sv/ring_tx_dma_segment_scheduler_assert.svh @@
// Assertion macros used by the ring transmit scheduler checker.
// Each macro expects i_clk and i_rst_n in scope and is disabled during reset.
`ifndef RING_TX_DMA_SEGMENT_SCHEDULER_ASSERT_SVH
`define RING_TX_DMA_SEGMENT_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define RTDS_ASSERT_NOW(label, ant, con) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("rtds same-cycle assertion failed");

// Next-cycle implication.
`define RTDS_ASSERT_NEXT(label, ant, con) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("rtds next-cycle assertion failed");

`endif

@@ sv/rtds_pkg.sv @@
`default_nettype none

package rtds_pkg;

    // Ring size in bytes; a power of two.
    localparam int RING_BYTES = 1024;
    localparam int IDX_W      = $clog2(RING_BYTES);
    localparam int CNT_W      = IDX_W + 1;

    // Fixed field widths of the beats.
    localparam int APPEND_W = 16;
    localparam int LEN_W    = 11;
    localparam int OFF_W    = 10;

    typedef enum logic {
        OP_APPEND   = 1'b0,
        OP_SEG_DONE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode               opcode;
        logic [APPEND_W-1:0]   append_len;
    } t_in_beat;

    typedef struct packed {
        logic [LEN_W-1:0] accepted_len;
        logic             seg_start;
        logic [OFF_W-1:0] seg_offset;
        logic [LEN_W-1:0] seg_length;
        logic             done_pulse;
        logic             busy_res;
        logic [LEN_W-1:0] free_space;
    } t_out_beat;

endpackage

`default_nettype wire

@@ sv/ring_tx_dma_segment_scheduler.sv @@
// An accepted input beat waits in the input register; its result beat is loaded into the
// output register when the beat advances, and leaves from there when not stalled.
// Throughput: 1 beat per cycle while the output is not stalled; the ring counters are read
// and updated in the same cycle the input register hands its beat to the output register.
// Reset (i_rst_n low, synchronous): counters and snapshot clear, engine idle, no chained
// segment pending, both pipeline registers empty.
`default_nettype none

module ring_tx_dma_segment_scheduler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rtds_pkg::t_in_beat  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rtds_pkg::t_out_beat o_out_data
);
    import rtds_pkg::*;

    localparam logic [CNT_W-1:0] RING_CNT = CNT_W'(RING_BYTES);
    localparam int CMP_W = (APPEND_W > CNT_W) ? APPEND_W : CNT_W;

    // Pipeline registers
    logic      r_in_valid;
    t_in_beat  r_in_data;
    logic      r_out_valid;
    t_out_beat r_out_data;
    t_out_beat n_out_data;

    // Ring state: counts run modulo 2*RING_BYTES so full and empty differ
    logic [CNT_W-1:0] r_write_count, n_write_count;
    logic [CNT_W-1:0] r_read_count,  n_read_count;
    logic [CNT_W-1:0] r_kick_snapshot, n_kick_snapshot;
    logic             r_seg_pending, n_seg_pending;
    logic             r_engine_idle, n_engine_idle;

    logic w_advance;

    // Event decode results
    logic [CNT_W-1:0] w_acc;
    logic [CNT_W-1:0] w_wc_a;
    logic [CNT_W-1:0] w_rc_a;
    logic             w_do_kick;
    logic             w_do_done;
    logic             w_chain_start;
    logic             w_pend_clr;
    logic [IDX_W-1:0] w_rest;

    // Helpers for the append path
    logic [CNT_W-1:0] w_used0;
    logic [CNT_W-1:0] w_free0;

    // Helpers for the chained-segment path
    logic [IDX_W-1:0] w_r_idx0;
    logic [CNT_W-1:0] w_step;
    logic [CNT_W-1:0] w_room;

    // Kick evaluation, from the counts after the event
    logic [CNT_W-1:0] k_used;
    logic [IDX_W-1:0] k_ridx;
    logic [IDX_W-1:0] k_widx;
    logic             k_wrap;
    logic [CNT_W-1:0] k_len;
    logic             k_pend;

    // Move a beat from the input register to the output register when the output
    // register is empty or is being drained this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_used0  = r_write_count - r_read_count;
    assign w_free0  = RING_CNT - w_used0;
    assign w_r_idx0 = r_read_count[IDX_W-1:0];
    assign w_step   = RING_CNT - CNT_W'(w_r_idx0);
    assign w_room   = r_kick_snapshot - r_read_count;
    assign w_rest   = r_kick_snapshot[IDX_W-1:0];

    // Decode the event held in the input register.
    always_comb begin
        w_acc         = '0;
        w_wc_a        = r_write_count;
        w_rc_a        = r_read_count;
        w_do_kick     = 1'b0;
        w_do_done     = 1'b0;
        w_chain_start = 1'b0;
        w_pend_clr    = 1'b0;
        unique case (r_in_data.opcode)
            OP_APPEND: begin
                // Clip the offer to free space, then kick only an idle engine.
                if (CMP_W'(r_in_data.append_len) < CMP_W'(w_free0)) begin
                    w_acc = CNT_W'(r_in_data.append_len);
                end else begin
                    w_acc = w_free0;
                end
                w_wc_a    = r_write_count + w_acc;
                w_do_kick = r_engine_idle && (w_wc_a != r_read_count);
            end
            OP_SEG_DONE: begin
                // A completion while idle is dropped.
                if (!r_engine_idle) begin
                    if (r_seg_pending) begin
                        // Advance to the ring end, never past the snapshot.
                        w_pend_clr = 1'b1;
                        w_rc_a     = r_read_count + ((w_step > w_room) ? w_room : w_step);
                        if (w_rest != '0) begin
                            w_chain_start = 1'b1;
                        end else if (r_write_count != w_rc_a) begin
                            w_do_kick = 1'b1;
                        end else begin
                            w_do_done = 1'b1;
                        end
                    end else begin
                        w_rc_a = r_kick_snapshot;
                        if (r_write_count != w_rc_a) begin
                            w_do_kick = 1'b1;
                        end else begin
                            w_do_done = 1'b1;
                        end
                    end
                end
            end
            default: begin
                w_acc = '0;
            end
        endcase
    end

    // Segment split at kick time: compare ring indices, not raw counts.
    assign k_used = w_wc_a - w_rc_a;
    assign k_ridx = w_rc_a[IDX_W-1:0];
    assign k_widx = w_wc_a[IDX_W-1:0];
    assign k_wrap = !(k_ridx < k_widx);
    assign k_len  = k_wrap ? (RING_CNT - CNT_W'(k_ridx)) : k_used;
    assign k_pend = k_wrap && (k_widx != '0);

    // Next state and result beat.
    always_comb begin
        n_write_count   = w_wc_a;
        n_read_count    = w_rc_a;
        n_kick_snapshot = w_do_kick ? w_wc_a : r_kick_snapshot;
        if (w_do_kick) begin
            n_seg_pending = k_pend;
        end else if (w_pend_clr) begin
            n_seg_pending = 1'b0;
        end else begin
            n_seg_pending = r_seg_pending;
        end
        if (w_do_kick) begin
            n_engine_idle = 1'b0;
        end else if (w_do_done) begin
            n_engine_idle = 1'b1;
        end else begin
            n_engine_idle = r_engine_idle;
        end

        n_out_data.accepted_len = LEN_W'(w_acc);
        n_out_data.seg_start    = w_do_kick || w_chain_start;
        n_out_data.seg_offset   = w_do_kick ? OFF_W'(k_ridx) : '0;
        if (w_do_kick) begin
            n_out_data.seg_length = LEN_W'(k_len);
        end else if (w_chain_start) begin
            n_out_data.seg_length = LEN_W'(w_rest);
        end else begin
            n_out_data.seg_length = '0;
        end
        n_out_data.done_pulse = w_do_done;
        n_out_data.busy_res   = !n_engine_idle;
        n_out_data.free_space = LEN_W'(RING_CNT - (n_write_count - n_read_count));
    end

    // Control state: pipeline valids and ring counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_write_count   <= '0;
            r_read_count    <= '0;
            r_kick_snapshot <= '0;
            r_seg_pending   <= 1'b0;
            r_engine_idle   <= 1'b1;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid     <= 1'b1;
                r_write_count   <= n_write_count;
                r_read_count    <= n_read_count;
                r_kick_snapshot <= n_kick_snapshot;
                r_seg_pending   <= n_seg_pending;
                r_engine_idle   <= n_engine_idle;
            end else if (!i_out_stall) begin
                // Result taken and nothing new behind it.
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/rtds_checker.sv @@
`default_nettype none
`include "ring_tx_dma_segment_scheduler_assert.svh"

module rtds_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_stall,
    input rtds_pkg::t_in_beat  i_in_data,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input rtds_pkg::t_out_beat i_out_data
);
    import rtds_pkg::*;

    logic w_ring_empty;
    logic w_within_ring;
    assign w_ring_empty  = (i_out_data.free_space == LEN_W'(RING_BYTES));
    assign w_within_ring = (i_out_data.free_space <= LEN_W'(RING_BYTES)) &&
                           (i_out_data.accepted_len <= LEN_W'(RING_BYTES));

    // A stalled input beat holds.
    `RTDS_ASSERT_NEXT(a_in_hold, i_in_valid && i_in_stall, i_in_valid && $stable(i_in_data))
    // A stalled result beat holds.
    `RTDS_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))
    // A launched segment leaves the engine busy with a nonempty length.
    `RTDS_ASSERT_NOW(a_start_busy, i_out_valid && i_out_data.seg_start, i_out_data.busy_res && (i_out_data.seg_length != '0))
    // Going idle means the ring is drained and nothing launched.
    `RTDS_ASSERT_NOW(a_done_empty, i_out_valid && i_out_data.done_pulse, !i_out_data.busy_res && !i_out_data.seg_start && w_ring_empty)
    // Free space and accepted length never exceed the ring.
    `RTDS_ASSERT_NOW(a_free_bound, i_out_valid, w_within_ring)

endmodule

bind ring_tx_dma_segment_scheduler rtds_checker u_rtds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
